/* rtl/opt_pkg.sv */
// Shared types, constants and a helper function for the ordered preset table.
package opt_pkg;

    // Default table depth and widths of the stored fields.
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int NAME_BYTES      = 8;
    localparam int NAME_W          = 64;
    localparam int BG_W            = 8;
    localparam int LAYER_W         = 16;

    // Width of a position; it covers every table depth up to 64 plus one.
    localparam int POS_W = 7;

    // Packed key of the reserved name "off".
    localparam logic [NAME_W-1:0] OFF_KEY = 64'h0000_0000_0066_666F;

    // Command opcodes.
    localparam logic [2:0] OP_APPLY      = 3'd0;
    localparam logic [2:0] OP_APPLY_NEXT = 3'd1;
    localparam logic [2:0] OP_FIND       = 3'd2;
    localparam logic [2:0] OP_INSERT     = 3'd3;
    localparam logic [2:0] OP_REMOVE     = 3'd4;
    localparam logic [2:0] OP_MOVE       = 3'd5;

    // One table entry.
    typedef struct packed {
        logic [NAME_W-1:0]  name;
        logic [BG_W-1:0]    background;
        logic [LAYER_W-1:0] layers;
    } entry_t;

    // Update command broadcast to every cell of the chain.
    typedef struct packed {
        logic             load_en;   // one cell takes the load entry
        logic [POS_W-1:0] load_pos;
        logic             shift_en;  // a run of cells takes a neighbor's entry
        logic             from_left; // 1: take from the lower position
        logic [POS_W-1:0] lo;        // first position of the run
        logic [POS_W-1:0] hi;        // last position of the run
    } cell_cmd_t;

    // Cut a key to NAME_BYTES bytes and clear every byte after the first zero byte.
    function automatic logic [NAME_W-1:0] norm_key(input logic [NAME_W-1:0] key);
        logic [NAME_W-1:0] r;
        logic              live;
        r    = '0;
        live = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (b >= NAME_BYTES || key[8*b +: 8] == 8'h00) begin
                live = 1'b0;
            end
            if (live) begin
                r[8*b +: 8] = key[8*b +: 8];
            end
        end
        return r;
    endfunction

endpackage

/* rtl/opt_cell.sv */
// One table cell: holds the entry at a fixed position and compares its name.
module opt_cell #(
    parameter int POS = 1
) (
    input  logic               aclk,
    input  opt_pkg::cell_cmd_t cmd,
    input  opt_pkg::entry_t    left_data,
    input  opt_pkg::entry_t    right_data,
    input  opt_pkg::entry_t    load_data,
    input  logic [opt_pkg::NAME_W-1:0] key,
    output opt_pkg::entry_t    data_reg,
    output logic               match
);

    localparam logic [opt_pkg::POS_W-1:0] MY_POS = opt_pkg::POS_W'(POS);

    opt_pkg::entry_t data_next;
    logic            in_run;

    // Decide whether this position lies inside the shifted run.
    assign in_run = cmd.shift_en && (MY_POS >= cmd.lo) && (MY_POS <= cmd.hi);

    // Pick the next entry: a load wins, then a shift, else hold.
    always_comb begin
        priority if (cmd.load_en && cmd.load_pos == MY_POS) begin
            data_next = load_data;
        end else if (in_run) begin
            data_next = cmd.from_left ? left_data : right_data;
        end else begin
            data_next = data_reg;
        end
    end

    // Entry storage; contents are undefined until written.
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    // Name compare for the find command.
    assign match = (data_reg.name == key);

endmodule

/* rtl/ordered_preset_table.sv */
// Top level of the ordered preset table: command decode, cell chain and result register.
//
// Each command arrives as one transfer on the s_ channel and yields exactly one
// result transfer on the m_ channel, held in the result register. A
// command is taken in every cycle in which the result register is empty or its
// result is being taken, so the block sustains one command per clock cycle: the
// whole chain of cells shifts, loads and compares at once, and the read
// of one entry for apply, apply next, remove and move is a single position mux.
// Entries hold no reset values and need no clearing pass; only positions up to
// the current count are ever read. Applying position 0 turns the output off.
module ordered_preset_table #(
    parameter int MAX_ENTRIES = opt_pkg::MAX_ENTRIES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata: opcode[2:0], index[7:3], target_index[12:8], name_key[76:13],
    //          new_background[84:77], new_layers[100:85], zero[103:101]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,
    // m_tdata: ok[0], active_index[5:1], active_background[13:6],
    //          active_layers[29:14], found_index[35:30], out_name[99:36],
    //          out_background[107:100], out_layers[123:108], apply_pulse[124],
    //          zero[127:125]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata
);

    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int POS_W = opt_pkg::POS_W;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_ENTRIES);

    // Unpacked input fields.
    logic [2:0]                  in_op;
    logic [4:0]                  in_idx;
    logic [4:0]                  in_tgt;
    logic [opt_pkg::NAME_W-1:0]  in_key;
    logic [opt_pkg::BG_W-1:0]    in_bg;
    logic [opt_pkg::LAYER_W-1:0] in_lay;

    assign in_op  = s_tdata[2:0];
    assign in_idx = s_tdata[7:3];
    assign in_tgt = s_tdata[12:8];
    assign in_key = opt_pkg::norm_key(s_tdata[76:13]);
    assign in_bg  = s_tdata[84:77];
    assign in_lay = s_tdata[100:85];

    // Control state.
    logic [CW-1:0]               cnt_reg,  cnt_next;
    logic [CW-1:0]               sel_reg,  sel_next;
    logic [opt_pkg::BG_W-1:0]    cur_bg_reg,  cur_bg_next;
    logic [opt_pkg::LAYER_W-1:0] cur_lay_reg, cur_lay_next;
    logic                        m_tvalid_reg;
    logic [127:0]                m_tdata_reg, m_tdata_next;

    logic accept;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Position arithmetic in a common width.
    logic [POS_W-1:0] idx_p, tgt_p, cnt_p, sel_p, next_p, rd_pos;
    assign idx_p = POS_W'(in_idx);
    assign tgt_p = POS_W'(in_tgt);
    assign cnt_p = POS_W'(cnt_reg);
    assign sel_p = POS_W'(sel_reg);

    // Next position for apply next, wrapping to 1 or to off.
    always_comb begin
        next_p = sel_p + POS_W'(1);
        if (next_p > cnt_p) begin
            next_p = (cnt_p != '0) ? POS_W'(1) : '0;
        end
    end

    assign rd_pos = (in_op == opt_pkg::OP_APPLY_NEXT) ? next_p : idx_p;

    // Cell chain.
    opt_pkg::entry_t    cell_q [MAX_ENTRIES];
    logic               cell_match [MAX_ENTRIES];
    opt_pkg::cell_cmd_t cmd;
    opt_pkg::entry_t    load_data;
    opt_pkg::entry_t    rd_data;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        opt_pkg::entry_t left_d, right_d;
        if (g == 0) begin : g_first
            assign left_d = cell_q[g];
        end else begin : g_mid_l
            assign left_d = cell_q[g-1];
        end
        if (g == MAX_ENTRIES - 1) begin : g_last
            assign right_d = cell_q[g];
        end else begin : g_mid_r
            assign right_d = cell_q[g+1];
        end
        opt_cell #(
            .POS (g + 1)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .left_data  (left_d),
            .right_data (right_d),
            .load_data  (load_data),
            .key        (in_key),
            .data_reg   (cell_q[g]),
            .match      (cell_match[g])
        );
    end

    // Read one entry by position; position 0 reads as zero.
    always_comb begin
        rd_data = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (rd_pos == POS_W'(i + 1)) begin
                rd_data = cell_q[i];
            end
        end
    end

    // First matching position among the valid entries.
    logic [5:0] found_pos;
    always_comb begin
        found_pos = 6'h3F;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (cell_match[i] && POS_W'(i + 1) <= cnt_p) begin
                found_pos = 6'(i + 1);
            end
        end
    end

    // Validity of each command.
    logic apply_ok, insert_ok, remove_ok, move_ok;
    assign apply_ok  = (idx_p <= cnt_p);
    assign insert_ok = (idx_p != '0) && (idx_p <= cnt_p + POS_W'(1)) && (cnt_p < MAX_POS);
    assign remove_ok = (idx_p != '0) && (idx_p <= cnt_p);
    assign move_ok   = remove_ok && (tgt_p != '0) && (tgt_p <= cnt_p);

    // Command decode and result assembly.
    logic                        ok, pulse;
    logic [5:0]                  found;
    opt_pkg::entry_t             removed;
    logic [POS_W-1:0]            act_pos;

    always_comb begin
        cmd          = '0;
        load_data    = rd_data;
        ok           = 1'b0;
        pulse        = 1'b0;
        found        = '0;
        removed      = '0;
        cnt_next     = cnt_reg;
        sel_next     = sel_reg;
        cur_bg_next  = cur_bg_reg;
        cur_lay_next = cur_lay_reg;

        unique case (in_op)
            opt_pkg::OP_APPLY, opt_pkg::OP_APPLY_NEXT: begin
                if (in_op == opt_pkg::OP_APPLY_NEXT || apply_ok) begin
                    ok           = 1'b1;
                    pulse        = 1'b1;
                    sel_next     = CW'(rd_pos);
                    cur_bg_next  = rd_data.background;
                    cur_lay_next = rd_data.layers;
                end
            end
            opt_pkg::OP_FIND: begin
                ok    = 1'b1;
                found = (in_key == opt_pkg::OFF_KEY) ? 6'd0 : found_pos;
            end
            opt_pkg::OP_INSERT: begin
                if (insert_ok) begin
                    ok               = 1'b1;
                    load_data.name       = in_key;
                    load_data.background = in_bg;
                    load_data.layers     = in_lay;
                    cmd.load_en      = 1'b1;
                    cmd.load_pos     = idx_p;
                    cmd.shift_en     = 1'b1;
                    cmd.from_left    = 1'b1;
                    cmd.lo           = idx_p + POS_W'(1);
                    cmd.hi           = cnt_p + POS_W'(1);
                    cnt_next         = cnt_reg + CW'(1);
                end
            end
            opt_pkg::OP_REMOVE: begin
                if (remove_ok) begin
                    ok            = 1'b1;
                    removed       = rd_data;
                    cmd.shift_en  = 1'b1;
                    cmd.from_left = 1'b0;
                    cmd.lo        = idx_p;
                    cmd.hi        = cnt_p - POS_W'(1);
                    cnt_next      = cnt_reg - CW'(1);
                end
            end
            opt_pkg::OP_MOVE: begin
                if (move_ok) begin
                    ok = 1'b1;
                    if (idx_p != tgt_p) begin
                        cmd.load_en  = 1'b1;
                        cmd.load_pos = tgt_p;
                        cmd.shift_en = 1'b1;
                        if (idx_p < tgt_p) begin
                            cmd.from_left = 1'b0;
                            cmd.lo        = idx_p;
                            cmd.hi        = tgt_p - POS_W'(1);
                        end else begin
                            cmd.from_left = 1'b1;
                            cmd.lo        = tgt_p + POS_W'(1);
                            cmd.hi        = idx_p;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // Nothing changes unless the command is actually transferred.
        if (!accept) begin
            cmd = '0;
        end

        act_pos      = POS_W'(sel_next);
        m_tdata_next = {3'b000, pulse, removed.layers, removed.background, removed.name,
                        found, cur_lay_next, cur_bg_next, act_pos[4:0], ok};
    end

    // Control state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            sel_reg      <= '0;
            cur_bg_reg   <= '0;
            cur_lay_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                cnt_reg      <= cnt_next;
                sel_reg      <= sel_next;
                cur_bg_reg   <= cur_bg_next;
                cur_lay_reg  <= cur_lay_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // The entry count never exceeds the table depth.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_ENTRIES))
        else $error("entry count above table depth");

    // A successful insert grows the table by exactly one entry.
    a_insert_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_op == opt_pkg::OP_INSERT && insert_ok)
            |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("insert did not grow the table");

    // A rejected command leaves the table size alone.
    a_reject_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !ok) |=> $stable(cnt_reg))
        else $error("rejected command changed the table size");

    // Table edits leave the active selection unchanged.
    a_edit_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_op == opt_pkg::OP_INSERT || in_op == opt_pkg::OP_REMOVE ||
                    in_op == opt_pkg::OP_MOVE)) |=> $stable(sel_reg))
        else $error("table edit changed the active selection");

    // A pending result is dropped only after its transfer.
    a_result_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_tvalid_reg) |-> $past(m_tready))
        else $error("result lost before transfer");

endmodule
